>>> rtl/ihf_pkg.sv
// Package for the IPv4 header finalize block.
// It holds the header word type, the default field values and the checksum fold.
// It has no dependencies.
package ihf_pkg;

    typedef struct packed {
        logic [7:0]  ver_hlen;
        logic [7:0]  tos;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [15:0] flags_fragment;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
    } t_hdr;

    localparam logic [7:0]  UDP_PROTO     = 8'd17;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [7:0]  DEFAULT_VIHL  = 8'h45;
    localparam logic [7:0]  DEFAULT_TTL   = 8'h40;
    localparam logic [15:0] DEFAULT_IDENT = 16'd1;
    localparam int          SUM_W         = 20;

    // Two end-around carry folds bring any 20-bit sum to 16 bits.
    function automatic logic [15:0] ones_fold(input logic [SUM_W-1:0] sum);
        logic [16:0] first;
        logic [16:0] second;
        first  = {13'd0, sum[SUM_W-1:16]} + {1'b0, sum[15:0]};
        second = {16'd0, first[16]} + {1'b0, first[15:0]};
        return second[15:0];
    endfunction

endpackage

>>> rtl/ihf_defaults.sv
// Default filling for the IPv4 header finalize block.
// It replaces zero fields by their defaults; it depends on ihf_pkg.
module ihf_defaults (
    input  ihf_pkg::t_hdr i_hdr,
    input  logic [15:0]   i_body_bytes,
    output ihf_pkg::t_hdr o_hdr
);

    logic [15:0] udp_length;

    assign udp_length = i_body_bytes + ihf_pkg::UDP_HDR_BYTES;

    always_comb begin
        o_hdr = i_hdr;
        if (i_hdr.total_length == 16'd0) begin
            o_hdr.total_length = (i_hdr.protocol == ihf_pkg::UDP_PROTO) ? udp_length
                                                                        : i_body_bytes;
        end
        if (i_hdr.ident == 16'd0) begin
            o_hdr.ident = ihf_pkg::DEFAULT_IDENT;
        end
        if (i_hdr.ttl == 8'd0) begin
            o_hdr.ttl = ihf_pkg::DEFAULT_TTL;
        end
        if (i_hdr.ver_hlen == 8'd0) begin
            o_hdr.ver_hlen = ihf_pkg::DEFAULT_VIHL;
        end
    end

endmodule

>>> rtl/ihf_csum.sv
// Header checksum for the IPv4 header finalize block.
// It adds the nine non-checksum header words and folds the carries; it depends on ihf_pkg.
module ihf_csum (
    input  ihf_pkg::t_hdr i_hdr,
    output logic [15:0]   o_checksum
);

    logic [ihf_pkg::SUM_W-1:0] sum_a;
    logic [ihf_pkg::SUM_W-1:0] sum_b;
    logic [ihf_pkg::SUM_W-1:0] sum_all;

    assign sum_a = {4'd0, i_hdr.ver_hlen, i_hdr.tos}
                 + {4'd0, i_hdr.total_length}
                 + {4'd0, i_hdr.ident}
                 + {4'd0, i_hdr.flags_fragment}
                 + {4'd0, i_hdr.ttl, i_hdr.protocol};
    assign sum_b = {4'd0, i_hdr.source_addr[31:16]}
                 + {4'd0, i_hdr.source_addr[15:0]}
                 + {4'd0, i_hdr.dest_addr[31:16]}
                 + {4'd0, i_hdr.dest_addr[15:0]};
    assign sum_all = sum_a + sum_b;

    assign o_checksum = ~ihf_pkg::ones_fold(sum_all);

endmodule

>>> rtl/ipv4_header_finalize_core.sv
// Top level of the IPv4 header finalize block.
// It holds the input and result registers around ihf_defaults and ihf_csum; it
// depends on ihf_pkg.
//
// Each accepted word is one IPv4 header plus a payload size. Zero version/IHL,
// ident, TTL and length fields are replaced by their defaults and the header
// checksum is computed. An accepted word passes through the input register and
// then the result register, with the default logic and the nine-word adder
// between them. One word is accepted in every cycle while the result side takes
// words; o_in_ready falls only when both registers hold words and i_out_ready
// is low.
module ipv4_header_finalize_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ver_hlen,
    input  logic [7:0]  i_tos,
    input  logic [15:0] i_total_length,
    input  logic [15:0] i_ident,
    input  logic [15:0] i_flags_fragment,
    input  logic [7:0]  i_ttl,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_source_addr,
    input  logic [31:0] i_dest_addr,
    input  logic [15:0] i_body_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_ver_hlen,
    output logic [7:0]  o_out_tos,
    output logic [15:0] o_out_length,
    output logic [15:0] o_out_ident,
    output logic [15:0] o_out_flags_fragment,
    output logic [7:0]  o_out_ttl,
    output logic [7:0]  o_out_protocol,
    output logic [15:0] o_header_checksum,
    output logic [31:0] o_out_source_addr,
    output logic [31:0] o_out_dest_addr
);

    logic          r_in_valid;
    ihf_pkg::t_hdr r_in_hdr;
    logic [15:0]   r_in_body_bytes;
    logic          r_out_valid;
    ihf_pkg::t_hdr r_out_hdr;
    logic [15:0]   r_out_checksum;

    ihf_pkg::t_hdr n_in_hdr;
    ihf_pkg::t_hdr n_out_hdr;
    logic [15:0]   n_out_checksum;
    logic          out_load;
    logic          in_load;

    assign out_load   = !r_out_valid || i_out_ready;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_ready = in_load;

    assign n_in_hdr = '{
        ver_hlen:       i_ver_hlen,
        tos:            i_tos,
        total_length:   i_total_length,
        ident:          i_ident,
        flags_fragment: i_flags_fragment,
        ttl:            i_ttl,
        protocol:       i_protocol,
        source_addr:    i_source_addr,
        dest_addr:      i_dest_addr
    };

    ihf_defaults u_defaults (
        .i_hdr        (r_in_hdr),
        .i_body_bytes (r_in_body_bytes),
        .o_hdr        (n_out_hdr)
    );

    ihf_csum u_csum (
        .i_hdr      (n_out_hdr),
        .o_checksum (n_out_checksum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_hdr        <= n_in_hdr;
            r_in_body_bytes <= i_body_bytes;
        end
        if (out_load && r_in_valid) begin
            r_out_hdr      <= n_out_hdr;
            r_out_checksum <= n_out_checksum;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_ver_hlen       = r_out_hdr.ver_hlen;
    assign o_out_tos            = r_out_hdr.tos;
    assign o_out_length         = r_out_hdr.total_length;
    assign o_out_ident          = r_out_hdr.ident;
    assign o_out_flags_fragment = r_out_hdr.flags_fragment;
    assign o_out_ttl            = r_out_hdr.ttl;
    assign o_out_protocol       = r_out_hdr.protocol;
    assign o_header_checksum    = r_out_checksum;
    assign o_out_source_addr    = r_out_hdr.source_addr;
    assign o_out_dest_addr      = r_out_hdr.dest_addr;

endmodule

>>> rtl/ihf_checker.sv
// Port checker for ipv4_header_finalize_core, attached by the bind below.
// It depends on ihf_pkg for the checksum fold.
module ihf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_ver_hlen,
    input logic [7:0]  o_out_tos,
    input logic [15:0] o_out_length,
    input logic [15:0] o_out_ident,
    input logic [15:0] o_out_flags_fragment,
    input logic [7:0]  o_out_ttl,
    input logic [7:0]  o_out_protocol,
    input logic [15:0] o_header_checksum,
    input logic [31:0] o_out_source_addr,
    input logic [31:0] o_out_dest_addr
);

    logic [ihf_pkg::SUM_W-1:0] verify_sum;

    assign verify_sum = {4'd0, o_out_ver_hlen, o_out_tos}
                      + {4'd0, o_out_length}
                      + {4'd0, o_out_ident}
                      + {4'd0, o_out_flags_fragment}
                      + {4'd0, o_out_ttl, o_out_protocol}
                      + {4'd0, o_header_checksum}
                      + {4'd0, o_out_source_addr[31:16]}
                      + {4'd0, o_out_source_addr[15:0]}
                      + {4'd0, o_out_dest_addr[31:16]}
                      + {4'd0, o_out_dest_addr[15:0]};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_header_checksum)
            && $stable(o_out_length))
        else $error("Stalled result word changed or was dropped.");

    a_checksum_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ihf_pkg::ones_fold(verify_sum) == 16'hFFFF)
        else $error("Result word fails the header checksum.");

    a_defaults_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_ver_hlen != 8'd0 && o_out_ttl != 8'd0
            && o_out_ident != 16'd0)
        else $error("Result word holds a zero field that should have a default.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input is stalled while the result register is empty.");

    a_no_stall_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("Input ready fell although the result side was ready.");

endmodule

bind ipv4_header_finalize_core ihf_checker u_ihf_checker (.*);

>>> tb/sv/ipv4_header_finalize_core_tb.sv
// Self-checking testbench for ipv4_header_finalize_core: a directed table, then random
// headers, with random idling on both handshakes and a built-in header predictor.
// It depends on ihf_pkg and the block's RTL.
module ipv4_header_finalize_core_tb;

    localparam int NUM_RANDOM  = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [7:0]  ver_hlen;
        logic [7:0]  tos;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [15:0] flags_fragment;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] body_bytes;
    } t_hdr_req;

    typedef struct packed {
        logic [7:0]  ver_hlen;
        logic [7:0]  tos;
        logic [15:0] length;
        logic [15:0] ident;
        logic [15:0] flags_fragment;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [15:0] checksum;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
    } t_hdr_fin;

    typedef struct packed {
        t_hdr_req req;
        logic     typed;
        t_hdr_fin fin;
    } t_hdr_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_ver_hlen;
    logic [7:0]  i_tos;
    logic [15:0] i_total_length;
    logic [15:0] i_ident;
    logic [15:0] i_flags_fragment;
    logic [7:0]  i_ttl;
    logic [7:0]  i_protocol;
    logic [31:0] i_source_addr;
    logic [31:0] i_dest_addr;
    logic [15:0] i_body_bytes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_ver_hlen;
    logic [7:0]  o_out_tos;
    logic [15:0] o_out_length;
    logic [15:0] o_out_ident;
    logic [15:0] o_out_flags_fragment;
    logic [7:0]  o_out_ttl;
    logic [7:0]  o_out_protocol;
    logic [15:0] o_header_checksum;
    logic [31:0] o_out_source_addr;
    logic [31:0] o_out_dest_addr;

    t_hdr_fin    pending_hdrs[$];
    t_hdr_fin    driven_fin;
    t_hdr_row    directed_rows[$];
    int          mismatches;
    int          cycle_count;
    logic        send_burst;
    logic        drain_burst;

    ipv4_header_finalize_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_ver_hlen           (i_ver_hlen),
        .i_tos                (i_tos),
        .i_total_length       (i_total_length),
        .i_ident              (i_ident),
        .i_flags_fragment     (i_flags_fragment),
        .i_ttl                (i_ttl),
        .i_protocol           (i_protocol),
        .i_source_addr        (i_source_addr),
        .i_dest_addr          (i_dest_addr),
        .i_body_bytes         (i_body_bytes),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_out_ver_hlen       (o_out_ver_hlen),
        .o_out_tos            (o_out_tos),
        .o_out_length         (o_out_length),
        .o_out_ident          (o_out_ident),
        .o_out_flags_fragment (o_out_flags_fragment),
        .o_out_ttl            (o_out_ttl),
        .o_out_protocol       (o_out_protocol),
        .o_header_checksum    (o_header_checksum),
        .o_out_source_addr    (o_out_source_addr),
        .o_out_dest_addr      (o_out_dest_addr)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic t_hdr_fin finalize_header(input t_hdr_req h);
        t_hdr_fin    f;
        logic [31:0] acc;
        f.ver_hlen       = (h.ver_hlen == 8'd0) ? ihf_pkg::DEFAULT_VIHL : h.ver_hlen;
        f.tos            = h.tos;
        f.ident          = (h.ident == 16'd0) ? ihf_pkg::DEFAULT_IDENT : h.ident;
        f.flags_fragment = h.flags_fragment;
        f.ttl            = (h.ttl == 8'd0) ? ihf_pkg::DEFAULT_TTL : h.ttl;
        f.protocol       = h.protocol;
        f.source_addr    = h.source_addr;
        f.dest_addr      = h.dest_addr;
        if (h.total_length != 16'd0) begin
            f.length = h.total_length;
        end else if (h.protocol == ihf_pkg::UDP_PROTO) begin
            f.length = h.body_bytes + ihf_pkg::UDP_HDR_BYTES;
        end else begin
            f.length = h.body_bytes;
        end
        // The checksum word itself enters the sum as zero.
        acc = {16'd0, f.ver_hlen, f.tos} + {16'd0, f.length} + {16'd0, f.ident}
            + {16'd0, f.flags_fragment} + {16'd0, f.ttl, f.protocol}
            + {16'd0, f.source_addr[31:16]} + {16'd0, f.source_addr[15:0]}
            + {16'd0, f.dest_addr[31:16]} + {16'd0, f.dest_addr[15:0]};
        while (acc > 32'h0000_FFFF) begin
            acc = (acc >> 16) + (acc & 32'h0000_FFFF);
        end
        f.checksum = ~acc[15:0];
        return f;
    endfunction

    function automatic t_hdr_row hdr_row(input logic [7:0] vihl, input logic [7:0] tos,
                                         input logic [15:0] len, input logic [15:0] ident,
                                         input logic [15:0] flg, input logic [7:0] ttl,
                                         input logic [7:0] proto, input logic [31:0] src,
                                         input logic [31:0] dst, input logic [15:0] pay);
        t_hdr_row r;
        r.req   = {vihl, tos, len, ident, flg, ttl, proto, src, dst, pay};
        r.typed = 1'b0;
        r.fin   = '0;
        return r;
    endfunction

    function automatic t_hdr_req random_header();
        t_hdr_req h;
        h.ver_hlen       = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        h.tos            = 8'($urandom);
        h.total_length   = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        h.ident          = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        h.flags_fragment = 16'($urandom);
        h.ttl            = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        case ($urandom_range(0, 3))
            0: h.protocol = ihf_pkg::UDP_PROTO;
            1: h.protocol = ($urandom_range(0, 1) == 0) ? ihf_pkg::UDP_PROTO - 8'd1
                                                        : ihf_pkg::UDP_PROTO + 8'd1;
            default: h.protocol = 8'($urandom);
        endcase
        h.source_addr    = $urandom;
        h.dest_addr      = $urandom;
        h.body_bytes     = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                                       : 16'($urandom);
        return h;
    endfunction

    task automatic send_header(input t_hdr_req h, input t_hdr_fin fin);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_ver_hlen       <= h.ver_hlen;
        i_tos            <= h.tos;
        i_total_length   <= h.total_length;
        i_ident          <= h.ident;
        i_flags_fragment <= h.flags_fragment;
        i_ttl            <= h.ttl;
        i_protocol       <= h.protocol;
        i_source_addr    <= h.source_addr;
        i_dest_addr      <= h.dest_addr;
        i_body_bytes     <= h.body_bytes;
        driven_fin       <= fin;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hdr_fin want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_hdrs.size() == 0) begin
                $error("result word with no expected header waiting");
                mismatches++;
            end else begin
                want = pending_hdrs.pop_front();
                check_field("out_ver_hlen", want.ver_hlen, o_out_ver_hlen);
                check_field("out_tos", want.tos, o_out_tos);
                check_field("out_length", want.length, o_out_length);
                check_field("out_ident", want.ident, o_out_ident);
                check_field("out_flags_fragment", want.flags_fragment, o_out_flags_fragment);
                check_field("out_ttl", want.ttl, o_out_ttl);
                check_field("out_protocol", want.protocol, o_out_protocol);
                check_field("header_checksum", want.checksum, o_header_checksum);
                check_field("out_source_addr", want.source_addr, o_out_source_addr);
                check_field("out_dest_addr", want.dest_addr, o_out_dest_addr);
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_hdrs.push_back(driven_fin);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ipv4_header_finalize_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int unsigned stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = drain_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin
        t_hdr_req h;
        t_hdr_fin fin;
        mismatches       = 0;
        cycle_count      = 0;
        send_burst       = 1'b0;
        drain_burst      = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_ver_hlen       = '0;
        i_tos            = '0;
        i_total_length   = '0;
        i_ident          = '0;
        i_flags_fragment = '0;
        i_ttl            = '0;
        i_protocol       = '0;
        i_source_addr    = '0;
        i_dest_addr      = '0;
        i_body_bytes     = '0;
        driven_fin       = '0;

        directed_rows.push_back(hdr_row(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                                        8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        directed_rows.push_back(hdr_row(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        directed_rows.push_back(hdr_row(8'h45, 8'h00, 16'h0000, 16'h1234, 16'h4000,
                                        8'h40, ihf_pkg::UDP_PROTO, 32'hC0A8_0001,
                                        32'hC0A8_00C7, 16'd100));
        directed_rows.push_back(hdr_row(8'h45, 8'h10, 16'h0000, 16'h0001, 16'h0000,
                                        8'h40, ihf_pkg::UDP_PROTO, 32'h0A00_0001,
                                        32'h0A00_0002, 16'hFFF8));
        directed_rows.push_back(hdr_row(8'h45, 8'h10, 16'h0000, 16'h0001, 16'h0000,
                                        8'h40, ihf_pkg::UDP_PROTO, 32'h0A00_0001,
                                        32'h0A00_0002, 16'hFFFF));
        directed_rows.push_back(hdr_row(8'h45, 8'h00, 16'h0000, 16'h0002, 16'h0000,
                                        8'h40, ihf_pkg::UDP_PROTO - 8'd1, 32'h0A00_0001,
                                        32'h0A00_0003, 16'hFFFF));
        directed_rows.push_back(hdr_row(8'h45, 8'h00, 16'h0000, 16'h0003, 16'h0000,
                                        8'h40, ihf_pkg::UDP_PROTO + 8'd1, 32'h0A00_0001,
                                        32'h0A00_0004, 16'd64));
        directed_rows.push_back(hdr_row(8'h45, 8'h00, 16'd28, 16'h0004, 16'h0000,
                                        8'h40, ihf_pkg::UDP_PROTO, 32'h0A00_0001,
                                        32'h0A00_0005, 16'd500));
        directed_rows.push_back(hdr_row(8'h01, 8'h80, 16'h0001, 16'hFFFF, 16'h8000,
                                        8'h01, 8'h06, 32'h8000_0000, 32'h0000_0001, 16'h8000));
        directed_rows.push_back(hdr_row(8'h00, 8'hAA, 16'hAAAA, 16'h0000, 16'h5555,
                                        8'h00, 8'h55, 32'hAAAA_5555, 32'h5555_AAAA, 16'h5555));
        directed_rows.push_back(hdr_row(8'hFE, 8'hFE, 16'hFFFE, 16'hFFFE, 16'hFFFE,
                                        8'hFE, 8'hFE, 32'hFFFE_FFFE, 32'hFFFE_FFFE, 16'h0000));
        directed_rows.push_back(hdr_row(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                                        8'h00, ihf_pkg::UDP_PROTO, 32'h0000_0000,
                                        32'h0000_0000, 16'h0000));
        directed_rows.push_back(hdr_row(8'h46, 8'h01, 16'h0000, 16'h0000, 16'hBFFF,
                                        8'h00, 8'h01, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 16'h0001));
        directed_rows.push_back(hdr_row(8'h7F, 8'h7F, 16'h7FFF, 16'h8000, 16'h0001,
                                        8'h80, 8'h80, 32'h0001_8000, 32'h8000_0001, 16'h7FFF));

        directed_rows[0].typed = 1'b1;
        directed_rows[0].fin   = {8'h45, 8'h00, 16'h0000, 16'h0001, 16'h0000, 8'h40, 8'h00,
                                  16'h7AFE, 32'h0000_0000, 32'h0000_0000};
        directed_rows[1].typed = 1'b1;
        directed_rows[1].fin   = {8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                  16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            fin = directed_rows[k].typed ? directed_rows[k].fin
                                         : finalize_header(directed_rows[k].req);
            send_header(directed_rows[k].req, fin);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if ($urandom_range(0, 63) == 0) begin
                send_burst = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 63) == 0) begin
                drain_burst = ($urandom_range(0, 2) == 0);
            end
            h = random_header();
            send_header(h, finalize_header(h));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_hdrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ipv4_header_finalize_core_tb OK");
        end else begin
            $display("ipv4_header_finalize_core_tb NOT OK");
        end
        $finish;
    end

endmodule
